@@ src/bpfa_pkg.sv @@
package bpfa_pkg;

    localparam int MAX_WORDS_DEF  = 256;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int WORD_BITS_DEF  = 32;

    localparam int ADDR_W = 25;
    localparam int REQ_W  = 2;
    localparam int CNT_W  = 14;
    localparam int CFG_W  = 9;

    localparam logic [CFG_W-1:0] WORDS_IN_USE_RESET = 9'd256;

    localparam logic [REQ_W-1:0] REQ_ALLOC      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE       = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE_RANGE = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HINT_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PICK,
        ST_FREE_RD,
        ST_FREE_WR
    } state_t;

endpackage

@@ src/bpfa_ram.sv @@
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/bpfa_zero_find.sv @@
module bpfa_zero_find #(
    parameter int WORD_BITS = bpfa_pkg::WORD_BITS_DEF,
    parameter int BIT_IDX_W = $clog2(WORD_BITS)
) (
    input  logic                 clk,
    input  logic [WORD_BITS-1:0] word,
    output logic [BIT_IDX_W-1:0] idx_reg
);

    logic [BIT_IDX_W-1:0] idx_next;

    // Highest clear bit wins; the caller only looks when one exists.
    always_comb
    begin
        idx_next = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (!word[i])
            begin
                idx_next = BIT_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

endmodule

@@ src/bitmap_page_frame_allocator_top.sv @@
// Channel   | Signals                                      | Handshake
// ----------+----------------------------------------------+----------------------------
// request   | req_type, page_address, page_count           | start high, busy low
// result    | status, alloc_address                        | done high for one cycle
// config    | cfg_data (words_in_use)                      | cfg_valid and cfg_ready
//
// An allocate first reads the bitmap word that holds the hint and checks the hint bit;
// on a miss it walks the bitmap words from the top down, with one memory read and one
// check each, and then locates the highest clear bit in the first word that has one.
// When the hint lies outside the pool, its word is never read and the walk starts
// straight from idle. A free reads and rewrites each word touched; requests that change
// nothing answer straight from idle. The bitmap RAM has a single read port.
// After reset the bitmap is zeroed one word at a time with busy high;
// configuration beats are taken at any time. Results cannot be stalled.
module bitmap_page_frame_allocator_top #(
    parameter int MAX_WORDS  = bpfa_pkg::MAX_WORDS_DEF,
    parameter int PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF,
    parameter int WORD_BITS  = bpfa_pkg::WORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bpfa_pkg::REQ_W-1:0]   req_type,
    input  logic [bpfa_pkg::ADDR_W-1:0]  page_address,
    input  logic [bpfa_pkg::CNT_W-1:0]   page_count,
    output logic                         done,
    output logic                         status,
    output logic [bpfa_pkg::ADDR_W-1:0]  alloc_address,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bpfa_pkg::CFG_W-1:0]   cfg_data
);

    localparam int WORD_IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int PAGE_W     = WORD_IDX_W + BIT_IDX_W;
    localparam int AW_W       = $clog2(MAX_WORDS + 1);
    localparam int LIM_W      = AW_W + BIT_IDX_W;
    localparam int APG_W      = bpfa_pkg::ADDR_W - PAGE_SHIFT;
    localparam int SUM_A      = (APG_W > bpfa_pkg::CNT_W) ? APG_W + 1 : bpfa_pkg::CNT_W + 1;
    localparam int SUM_W      = (SUM_A > LIM_W) ? SUM_A : LIM_W;
    localparam int ADDR_W     = bpfa_pkg::ADDR_W;

    bpfa_pkg::state_t state_reg, state_next;

    logic [PAGE_W-1:0]              hint_reg, hint_next;
    logic [bpfa_pkg::CFG_W-1:0]     words_in_use_reg;
    logic [WORD_IDX_W-1:0]          clr_addr_reg, clr_addr_next;
    logic [WORD_IDX_W-1:0]          word_idx_reg, word_idx_next;
    logic [WORD_IDX_W-1:0]          last_word_reg, last_word_next;
    logic [BIT_IDX_W-1:0]           lo_bit_reg, lo_bit_next;
    logic [BIT_IDX_W-1:0]           hi_bit_reg, hi_bit_next;
    logic                           done_reg, done_next;
    logic                           status_reg, status_next;
    logic [ADDR_W-1:0]              alloc_address_reg, alloc_address_next;

    logic                           ram_wr_en;
    logic [WORD_IDX_W-1:0]          ram_wr_addr;
    logic [WORD_BITS-1:0]           ram_wr_data;
    logic                           ram_rd_en;
    logic [WORD_IDX_W-1:0]          ram_rd_addr;
    logic [WORD_BITS-1:0]           ram_rd_data;
    logic [BIT_IDX_W-1:0]           find_idx;

    logic [AW_W-1:0]                active_words;
    logic [SUM_W-1:0]               limit;
    logic [SUM_W-1:0]               page_in;
    logic [SUM_W-1:0]               cnt_in;
    logic [SUM_W-1:0]               end_raw;
    logic [SUM_W-1:0]               end_clip;
    logic [SUM_W-1:0]               end_m1;
    logic                           range_live;
    logic                           hint_ok;
    logic                           accept;
    logic                           hint_free;
    logic                           word_full;
    logic [BIT_IDX_W-1:0]           hi_sel;
    logic [WORD_BITS-1:0]           free_mask;
    logic [WORD_BITS-1:0]           pick_bit;
    logic [PAGE_W-1:0]              pick;
    logic [PAGE_W+PAGE_SHIFT-1:0]   pick_shifted;

    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_WORDS),
        .AW    (WORD_IDX_W)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bpfa_zero_find #(
        .WORD_BITS (WORD_BITS),
        .BIT_IDX_W (BIT_IDX_W)
    ) u_find (
        .clk     (clk),
        .word    (ram_rd_data),
        .idx_reg (find_idx)
    );

    assign busy          = (state_reg != bpfa_pkg::ST_IDLE);
    assign accept        = start && !busy;
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign status        = status_reg;
    assign alloc_address = alloc_address_reg;

    // Request decode shared by the next-state and datapath logic.
    always_comb
    begin
        active_words = (32'(words_in_use_reg) > 32'(MAX_WORDS)) ?
                       AW_W'(MAX_WORDS) : AW_W'(words_in_use_reg);
        limit        = SUM_W'(active_words) << BIT_IDX_W;
        page_in      = SUM_W'(page_address >> PAGE_SHIFT);
        cnt_in       = (req_type == bpfa_pkg::REQ_FREE) ? SUM_W'(1) : SUM_W'(page_count);
        end_raw      = page_in + cnt_in;
        end_clip     = (end_raw > limit) ? limit : end_raw;
        end_m1       = end_clip - SUM_W'(1);
        range_live   = (end_clip > page_in);
        hint_ok      = (SUM_W'(hint_reg) < limit);
        hint_free    = !ram_rd_data[hint_reg[BIT_IDX_W-1:0]];
        word_full    = (ram_rd_data == {WORD_BITS{1'b1}});
        hi_sel       = (word_idx_reg == last_word_reg) ? hi_bit_reg : {BIT_IDX_W{1'b1}};
        free_mask    = ({WORD_BITS{1'b1}} << lo_bit_reg) &
                       ({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) - hi_sel));
        pick         = (state_reg == bpfa_pkg::ST_PICK) ? {word_idx_reg, find_idx} : hint_reg;
        pick_bit     = {{(WORD_BITS-1){1'b0}}, 1'b1} << pick[BIT_IDX_W-1:0];
        pick_shifted = {pick, {PAGE_SHIFT{1'b0}}};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpfa_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == WORD_IDX_W'(MAX_WORDS - 1))
                begin
                    state_next = bpfa_pkg::ST_IDLE;
                end
            end
            bpfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == bpfa_pkg::REQ_ALLOC)
                    begin
                        if (hint_ok)
                        begin
                            state_next = bpfa_pkg::ST_HINT_CHK;
                        end
                        else if (active_words != '0)
                        begin
                            state_next = bpfa_pkg::ST_SCAN_RD;
                        end
                    end
                    else if ((req_type == bpfa_pkg::REQ_FREE ||
                              req_type == bpfa_pkg::REQ_FREE_RANGE) && range_live)
                    begin
                        state_next = bpfa_pkg::ST_FREE_RD;
                    end
                end
            end
            bpfa_pkg::ST_HINT_CHK:
            begin
                state_next = hint_free ? bpfa_pkg::ST_IDLE : bpfa_pkg::ST_SCAN_RD;
            end
            bpfa_pkg::ST_SCAN_RD:
            begin
                state_next = bpfa_pkg::ST_SCAN_CHK;
            end
            bpfa_pkg::ST_SCAN_CHK:
            begin
                priority if (!word_full)
                begin
                    state_next = bpfa_pkg::ST_PICK;
                end
                else if (word_idx_reg == '0)
                begin
                    state_next = bpfa_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bpfa_pkg::ST_SCAN_RD;
                end
            end
            bpfa_pkg::ST_PICK:
            begin
                state_next = bpfa_pkg::ST_IDLE;
            end
            bpfa_pkg::ST_FREE_RD:
            begin
                state_next = bpfa_pkg::ST_FREE_WR;
            end
            bpfa_pkg::ST_FREE_WR:
            begin
                state_next = (word_idx_reg == last_word_reg) ?
                             bpfa_pkg::ST_IDLE : bpfa_pkg::ST_FREE_RD;
            end
            default:
            begin
                state_next = bpfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hint_next          = hint_reg;
        clr_addr_next      = clr_addr_reg;
        word_idx_next      = word_idx_reg;
        last_word_next     = last_word_reg;
        lo_bit_next        = lo_bit_reg;
        hi_bit_next        = hi_bit_reg;
        done_next          = 1'b0;
        status_next        = status_reg;
        alloc_address_next = alloc_address_reg;
        ram_wr_en          = 1'b0;
        ram_wr_addr        = word_idx_reg;
        ram_wr_data        = ram_rd_data | pick_bit;
        ram_rd_en          = 1'b0;
        ram_rd_addr        = word_idx_reg;

        unique case (state_reg)
            bpfa_pkg::ST_CLEAR:
            begin
                ram_wr_en     = 1'b1;
                ram_wr_addr   = clr_addr_reg;
                ram_wr_data   = '0;
                clr_addr_next = clr_addr_reg + WORD_IDX_W'(1);
            end
            bpfa_pkg::ST_IDLE:
            begin
                ram_rd_addr   = hint_reg[PAGE_W-1:BIT_IDX_W];
                word_idx_next = WORD_IDX_W'(active_words - AW_W'(1));
                if (accept)
                begin
                    ram_rd_en          = 1'b1;
                    status_next        = bpfa_pkg::STATUS_OK;
                    alloc_address_next = '0;
                    if (req_type == bpfa_pkg::REQ_ALLOC)
                    begin
                        if (!hint_ok && active_words == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = bpfa_pkg::STATUS_OOM;
                        end
                    end
                    else if ((req_type == bpfa_pkg::REQ_FREE ||
                              req_type == bpfa_pkg::REQ_FREE_RANGE) && range_live)
                    begin
                        word_idx_next  = WORD_IDX_W'(page_in >> BIT_IDX_W);
                        last_word_next = WORD_IDX_W'(end_m1 >> BIT_IDX_W);
                        lo_bit_next    = page_in[BIT_IDX_W-1:0];
                        hi_bit_next    = end_m1[BIT_IDX_W-1:0];
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            bpfa_pkg::ST_HINT_CHK:
            begin
                if (hint_free)
                begin
                    ram_wr_en          = 1'b1;
                    ram_wr_addr        = hint_reg[PAGE_W-1:BIT_IDX_W];
                    hint_next          = (pick != '0) ? pick - PAGE_W'(1) : '0;
                    alloc_address_next = ADDR_W'(pick_shifted);
                    done_next          = 1'b1;
                end
            end
            bpfa_pkg::ST_SCAN_RD:
            begin
                ram_rd_en = 1'b1;
            end
            bpfa_pkg::ST_SCAN_CHK:
            begin
                if (word_full)
                begin
                    if (word_idx_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = bpfa_pkg::STATUS_OOM;
                    end
                    else
                    begin
                        word_idx_next = word_idx_reg - WORD_IDX_W'(1);
                    end
                end
            end
            bpfa_pkg::ST_PICK:
            begin
                // The read data register still holds the scanned word.
                ram_wr_en          = 1'b1;
                hint_next          = (pick != '0) ? pick - PAGE_W'(1) : '0;
                alloc_address_next = ADDR_W'(pick_shifted);
                done_next          = 1'b1;
            end
            bpfa_pkg::ST_FREE_RD:
            begin
                ram_rd_en = 1'b1;
            end
            bpfa_pkg::ST_FREE_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data & ~free_mask;
                if (word_idx_reg == last_word_reg)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    word_idx_next = word_idx_reg + WORD_IDX_W'(1);
                    lo_bit_next   = '0;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bpfa_pkg::ST_CLEAR;
            hint_reg         <= '0;
            words_in_use_reg <= bpfa_pkg::WORDS_IN_USE_RESET;
            clr_addr_reg     <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hint_reg     <= hint_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                words_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_idx_reg      <= word_idx_next;
        last_word_reg     <= last_word_next;
        lo_bit_reg        <= lo_bit_next;
        hi_bit_reg        <= hi_bit_next;
        status_reg        <= status_next;
        alloc_address_reg <= alloc_address_next;
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int REQ_W          = bpfa_pkg::REQ_W;
    localparam int ADDR_W         = bpfa_pkg::ADDR_W;
    localparam int CNT_W          = bpfa_pkg::CNT_W;
    localparam int CFG_W          = bpfa_pkg::CFG_W;
    localparam int WORD_BITS_DEF  = bpfa_pkg::WORD_BITS_DEF;
    localparam int MAX_WORDS_DEF  = bpfa_pkg::MAX_WORDS_DEF;
    localparam int PAGE_SHIFT_DEF = bpfa_pkg::PAGE_SHIFT_DEF;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int QUIET_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 160;
    localparam int CHUNK_ITEMS   = 40;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] alloc_address;
    } reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [REQ_W-1:0]  req_type = '0;
    logic [ADDR_W-1:0] page_address = '0;
    logic [CNT_W-1:0]  page_count = '0;
    logic              done;
    logic              status;
    logic [ADDR_W-1:0] alloc_address;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;

    // Shadow of the allocator state.
    logic [WORD_BITS_DEF-1:0] page_map [MAX_WORDS_DEF];
    logic [12:0]              hint_page = '0;
    logic [CFG_W-1:0]         map_words = bpfa_pkg::WORDS_IN_USE_RESET;

    reply_t reply_q [$];
    int     fail_count = 0;
    int     quiet_cycles = 0;
    bit     steady = 1'b0;

    bitmap_page_frame_allocator_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .page_address  (page_address),
        .page_count    (page_count),
        .done          (done),
        .status        (status),
        .alloc_address (alloc_address),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        foreach (page_map[i])
            page_map[i] = '0;
    end

    function automatic int unsigned managed_pages(input logic [CFG_W-1:0] words);
        int unsigned active;
        active = (words > MAX_WORDS_DEF) ? MAX_WORDS_DEF : words;
        return active * WORD_BITS_DEF;
    endfunction

    // Applies one request to the shadow bitmap and returns the reply it must produce.
    function automatic reply_t serve_request(input logic [REQ_W-1:0] kind,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic [CNT_W-1:0] cnt);
        reply_t      r;
        int unsigned limit;
        int unsigned page;
        int unsigned pick;
        int unsigned w;
        int unsigned b;
        bit          found;
        r.status        = bpfa_pkg::STATUS_OK;
        r.alloc_address = '0;
        limit = managed_pages(map_words);
        page  = addr >> PAGE_SHIFT_DEF;
        found = 1'b0;
        pick  = 0;
        unique case (kind)
            bpfa_pkg::REQ_ALLOC:
            begin
                if (hint_page < limit
                    && !page_map[hint_page / WORD_BITS_DEF][hint_page % WORD_BITS_DEF])
                begin
                    pick  = hint_page;
                    found = 1'b1;
                end
                else
                begin
                    // Walk words from the top, then bits from the top, for a free page.
                    for (w = limit / WORD_BITS_DEF; w > 0 && !found; w--)
                    begin
                        if (page_map[w-1] != '1)
                        begin
                            for (b = WORD_BITS_DEF; b > 0 && !found; b--)
                            begin
                                if (!page_map[w-1][b-1])
                                begin
                                    pick  = (w - 1) * WORD_BITS_DEF + b - 1;
                                    found = 1'b1;
                                end
                            end
                        end
                    end
                end
                if (found)
                begin
                    page_map[pick / WORD_BITS_DEF][pick % WORD_BITS_DEF] = 1'b1;
                    hint_page       = (pick > 0) ? 13'(pick - 1) : '0;
                    r.alloc_address = ADDR_W'(pick << PAGE_SHIFT_DEF);
                end
                else
                begin
                    r.status = bpfa_pkg::STATUS_OOM;
                end
            end
            bpfa_pkg::REQ_FREE:
            begin
                if (page < limit)
                    page_map[page / WORD_BITS_DEF][page % WORD_BITS_DEF] = 1'b0;
            end
            bpfa_pkg::REQ_FREE_RANGE:
            begin
                for (int unsigned i = 0; i < cnt && page + i < limit; i++)
                    page_map[(page + i) / WORD_BITS_DEF][(page + i) % WORD_BITS_DEF] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Mostly back to back, sometimes a short gap, now and then a long pause.
    function automatic int next_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [ADDR_W-1:0] addr,
                                input logic [CNT_W-1:0] cnt);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= kind;
        page_address <= addr;
        page_count   <= cnt;
        do
            @(posedge clk);
        while (busy);
        reply_q.push_back(serve_request(kind, addr, cnt));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (reply_q.size() != 0 || busy);
    endtask

    task automatic write_words_in_use(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        map_words = value;
    endtask

    function automatic logic [ADDR_W-1:0] page_addr(input int unsigned page);
        return {13'(page), 12'($urandom)};
    endfunction

    // Hint hits, the downward scan, odd low address bits, and range ends.
    task automatic test_hint_and_scan();
        send_request(bpfa_pkg::REQ_ALLOC, '0, '0);
        send_request(bpfa_pkg::REQ_ALLOC, '1, '1);
        send_request(bpfa_pkg::REQ_ALLOC, page_addr(5), 14'd3);
        send_request(bpfa_pkg::REQ_FREE, 25'h1FF_FFFF, '0);
        send_request(bpfa_pkg::REQ_ALLOC, '0, '0);
        send_request(bpfa_pkg::REQ_FREE_RANGE, page_addr(8185), '0);
        send_request(bpfa_pkg::REQ_FREE_RANGE, page_addr(8180), '1);
        send_request(REQ_UNKNOWN, '1, '1);
        send_request(bpfa_pkg::REQ_FREE, 25'h000_0FFF, '0);
        send_request(bpfa_pkg::REQ_ALLOC, '0, '0);
    endtask

    // Empty pool, oversized setting, and a one-word pool with the hint out of range.
    task automatic test_pool_sizes();
        write_words_in_use(9'd0);
        send_request(bpfa_pkg::REQ_ALLOC, '0, '0);
        send_request(bpfa_pkg::REQ_FREE, '0, '0);
        send_request(bpfa_pkg::REQ_FREE_RANGE, '0, 14'd5);
        write_words_in_use(9'd511);
        send_request(bpfa_pkg::REQ_ALLOC, '0, '0);
        write_words_in_use(9'd1);
        send_request(bpfa_pkg::REQ_ALLOC, '0, '0);
        send_request(bpfa_pkg::REQ_FREE, page_addr(40), '0);
        send_request(bpfa_pkg::REQ_FREE_RANGE, page_addr(30), 14'd5);
        send_request(bpfa_pkg::REQ_ALLOC, '0, '0);
        send_request(REQ_UNKNOWN, '0, '0);
    endtask

    task automatic send_random_item(input int unsigned pages, input bit filling);
        int                r;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  cnt;
        r = $urandom_range(0, 99);
        if (pages > 0 && $urandom_range(0, 9) < 8)
            addr = page_addr($urandom_range(0, pages - 1));
        else
            addr = ADDR_W'($urandom);
        if ($urandom_range(0, 99) < 88)
            cnt = CNT_W'($urandom_range(0, 48));
        else
            cnt = CNT_W'($urandom);
        if (filling)
            r = (r < 90) ? 0 : r;
        if (r < 50)
            send_request(bpfa_pkg::REQ_ALLOC, ADDR_W'($urandom), CNT_W'($urandom));
        else if (r < 76)
            send_request(bpfa_pkg::REQ_FREE, addr, cnt);
        else if (r < 93)
            send_request(bpfa_pkg::REQ_FREE_RANGE, addr, cnt);
        else
            send_request(REQ_UNKNOWN, addr, cnt);
    endtask

    // Phases over several pool sizes; each alternates filling bursts with churn so
    // the small pools run out of memory and recover.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] sizes [12];
        int unsigned      pages;
        bit               filling;
        sizes = '{9'd1, 9'd2, 9'd256, 9'd4, 9'd0, 9'd3, 9'd511, 9'd1,
                  9'd8, 9'd300, 9'd2, 9'd256};
        foreach (sizes[p])
        begin
            write_words_in_use(sizes[p]);
            pages = managed_pages(sizes[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % CHUNK_ITEMS == 0)
                begin
                    steady  = ($urandom_range(0, 3) == 0);
                    filling = ($urandom_range(0, 1) == 0);
                end
                send_random_item(pages, filling);
            end
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (rst_n && done)
        begin
            if (reply_q.size() == 0)
            begin
                $error("unexpected result: status %0d alloc_address 0x%0h",
                       status, alloc_address);
                fail_count++;
            end
            else
            begin
                want = reply_q.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
                if (alloc_address !== want.alloc_address)
                begin
                    $error("alloc_address: expected 0x%0h, actual 0x%0h",
                           want.alloc_address, alloc_address);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_hint_and_scan();
        test_pool_sizes();
        test_random_traffic();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ bitmap_page_frame_allocator_top.f @@
src/bpfa_pkg.sv
src/bpfa_ram.sv
src/bpfa_zero_find.sv
src/bitmap_page_frame_allocator_top.sv
bench/tb.sv
